@@ src/lfurp_pkg.sv @@
// package for the lfu replacement policy block
// holds request codes, field widths and the structs shared by the top level and the cells
// no dependencies

package lfurp_pkg;

  // fixed field widths of the request and result items
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned FRAME_W  = 6;
  localparam int unsigned MASK_W   = 64;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned FRAMES_MAX = 64;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 3'd0,
    REQ_LOAD   = 3'd1,
    REQ_ACCESS = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_PICK   = 3'd4
  } req_type_e;

  // control state of the top level
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } lfurp_state_e;

  // update broadcast to every cell
  typedef struct packed {
    logic               clear;
    logic               load;
    logic               access;
    logic               remove;
    logic [FRAME_W-1:0] frame;
  } cell_op_t;

  // scan token handed from cell to cell (count travels beside it)
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [FRAME_W-1:0] frame;
    logic [STAMP_W-1:0] age;
  } scan_tok_t;

endpackage

@@ src/lfurp_if.sv @@
// handshake interfaces for the request and result channels
// depends on lfurp_pkg for the field widths

interface lfurp_req_if
  import lfurp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [FRAME_W-1:0] frame_index;
  logic [MASK_W-1:0] candidate_mask;

  modport source (output valid, output req_type, output frame_index,
                  output candidate_mask, input ready);
  modport sink   (input valid, input req_type, input frame_index,
                  input candidate_mask, output ready);
endinterface

interface lfurp_res_if
  import lfurp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               victim_found;
  logic [FRAME_W-1:0] victim_frame;

  modport source (output valid, output victim_found, output victim_frame, input ready);
  modport sink   (input valid, input victim_found, input victim_frame, output ready);
endinterface

@@ src/lfu_replacement_policy.sv @@
// Least-frequently-used replacement policy over NUM_FRAMES buffer frames, with the oldest
// last use breaking ties. Each frame lives in its own cell of a chain; clear, load, access
// and remove take effect in the cycle the item is accepted, so such items can follow one
// another every cycle while no pick is in flight. A pick sends a scan token down the chain,
// one cell per cycle, from the start register through every cell to the result register and
// then the output register, and no new item is taken until the result has moved to the output
// register. Depends on lfurp_pkg, lfurp_if and lfurp_cell.

module lfu_replacement_policy
  import lfurp_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = 64,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lfurp_req_if.sink   req_i,
  lfurp_res_if.source res_o
);

  lfurp_state_e state_q, state_d;

  logic [STAMP_W-1:0]    seq_q, seq_d;
  logic [NUM_FRAMES-1:0] mask_q;
  logic                  start_q;
  logic                  res_found_q;
  logic [FRAME_W-1:0]    res_frame_q;
  logic                  out_valid_q, out_valid_d;
  logic                  out_found_q;
  logic [FRAME_W-1:0]    out_frame_q;

  logic                  accept;
  logic                  in_range;
  logic                  is_pick;
  logic                  capture;
  logic                  load_out;
  logic [NUM_FRAMES-1:0] tracked_vec;
  logic [FRAMES_MAX-1:0] tracked_pad;
  cell_op_t              op;

  scan_tok_t             tok     [NUM_FRAMES+1];
  logic [COUNT_BITS-1:0] tok_cnt [NUM_FRAMES+1];

  assign accept      = req_i.valid && req_i.ready;
  assign in_range    = {1'b0, req_i.frame_index} < (FRAME_W + 1)'(NUM_FRAMES);
  assign is_pick     = (req_i.req_type == REQ_PICK);
  assign tracked_pad = FRAMES_MAX'(tracked_vec);

  // update broadcast to the cells
  always_comb begin
    op.clear  = accept && (req_i.req_type == REQ_CLEAR);
    op.load   = accept && (req_i.req_type == REQ_LOAD);
    op.access = accept && (req_i.req_type == REQ_ACCESS);
    op.remove = accept && (req_i.req_type == REQ_REMOVE);
    op.frame  = req_i.frame_index;
  end

  // sequence counter: each load or tracked access takes a stamp, and a clear resets it
  always_comb begin
    seq_d = seq_q;
    priority if (op.clear) begin
      seq_d = '0;
    end else if (op.load && in_range) begin
      seq_d = seq_q + STAMP_W'(1);
    end else if (op.access && in_range && tracked_pad[req_i.frame_index]) begin
      seq_d = seq_q + STAMP_W'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && is_pick) state_d = ST_SCAN;
      ST_SCAN: if (tok[NUM_FRAMES].valid) state_d = ST_HOLD;
      ST_HOLD: if (!out_valid_q || res_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req_i.ready = 1'b0;
    capture     = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      ST_IDLE: req_i.ready = 1'b1;
      ST_SCAN: capture = tok[NUM_FRAMES].valid;
      ST_HOLD: load_out = !out_valid_q || res_o.ready;
      default: req_i.ready = 1'b0;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seq_q       <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seq_q       <= seq_d;
      start_q     <= accept && is_pick;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept && is_pick) begin
      mask_q <= req_i.candidate_mask[NUM_FRAMES-1:0];
    end
    if (capture) begin
      res_found_q <= tok[NUM_FRAMES].found;
      res_frame_q <= tok[NUM_FRAMES].frame;
    end
    if (load_out) begin
      out_found_q <= res_found_q;
      out_frame_q <= res_frame_q;
    end
  end

  // token entering the chain
  assign tok[0]     = '{valid: start_q, found: 1'b0, frame: '0, age: '0};
  assign tok_cnt[0] = '0;

  // chain of frame cells
  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    lfurp_cell #(
      .IDX        (i),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .op_i       (op),
      .seq_i      (seq_q),
      .mask_bit_i (mask_q[i]),
      .tok_i      (tok[i]),
      .tok_cnt_i  (tok_cnt[i]),
      .tok_o      (tok[i+1]),
      .tok_cnt_o  (tok_cnt[i+1]),
      .tracked_o  (tracked_vec[i])
    );
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.victim_found = out_found_q;
  assign res_o.victim_frame = out_frame_q;

  // a result without a victim reports frame zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.victim_found) |-> (res_o.victim_frame == '0))
    else $error("empty pick result carries a nonzero frame");

  // the scan token leaves the chain only while a pick is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[NUM_FRAMES].valid |-> (state_q == ST_SCAN))
    else $error("scan token left the chain outside a pick");

  // no item is taken while a pick is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !req_i.ready)
    else $error("request taken during a pick");

  // a clear restarts the sequence counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.req_type == REQ_CLEAR)) |=> (seq_q == '0))
    else $error("sequence counter not cleared");

endmodule

@@ src/lfurp_cell.sv @@
// one frame cell: tracked flag, saturating use count and stamp of last use
// compares its entry against the passing scan token; depends on lfurp_pkg

module lfurp_cell
  import lfurp_pkg::*;
#(
  parameter int unsigned IDX        = 0,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_op_t              op_i,
  input  logic [STAMP_W-1:0]    seq_i,
  input  logic                  mask_bit_i,
  input  scan_tok_t             tok_i,
  input  logic [COUNT_BITS-1:0] tok_cnt_i,
  output scan_tok_t             tok_o,
  output logic [COUNT_BITS-1:0] tok_cnt_o,
  output logic                  tracked_o
);

  logic                  tracked_q, tracked_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [STAMP_W-1:0]    stamp_q, stamp_d;
  scan_tok_t             tok_q, tok_d;
  logic [COUNT_BITS-1:0] tok_cnt_q, tok_cnt_d;

  logic               hit;
  logic [STAMP_W-1:0] age;
  logic               take;

  assign hit = (op_i.frame == FRAME_W'(IDX));

  // entry update from load, access, remove and clear
  always_comb begin
    tracked_d = tracked_q;
    count_d   = count_q;
    stamp_d   = stamp_q;
    if (op_i.clear) begin
      tracked_d = 1'b0;
    end else if (op_i.load && hit) begin
      tracked_d = 1'b1;
      count_d   = COUNT_BITS'(1);
      stamp_d   = seq_i;
    end else if (op_i.access && hit && tracked_q) begin
      if (count_q != '1) begin
        count_d = count_q + COUNT_BITS'(1);
      end
      stamp_d = seq_i;
    end else if (op_i.remove && hit) begin
      tracked_d = 1'b0;
    end
  end

  // lowest count wins, older stamp breaks a tie, earlier cell keeps an exact tie
  assign age  = seq_i - stamp_q;
  assign take = mask_bit_i && tracked_q &&
                (!tok_i.found || (count_q < tok_cnt_i) ||
                 ((count_q == tok_cnt_i) && (age > tok_i.age)));

  always_comb begin
    tok_d     = tok_i;
    tok_cnt_d = tok_cnt_i;
    if (take) begin
      tok_d.found = 1'b1;
      tok_d.frame = FRAME_W'(IDX);
      tok_d.age   = age;
      tok_cnt_d   = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracked_q <= 1'b0;
      tok_q     <= '0;
    end else begin
      tracked_q <= tracked_d;
      tok_q     <= tok_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    count_q   <= count_d;
    stamp_q   <= stamp_d;
    tok_cnt_q <= tok_cnt_d;
  end

  assign tok_o     = tok_q;
  assign tok_cnt_o = tok_cnt_q;
  assign tracked_o = tracked_q;

endmodule
